### design/vsfr_pkg.sv
// Shared constants and types for the vehicle status frame receiver.
package vsfr_pkg;

  // Frame layout
  localparam int unsigned PayloadLen = 13;
  localparam int unsigned IdxW       = $clog2(PayloadLen);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(PayloadLen - 1);

  // Header and trailer bytes
  localparam logic [7:0] ChS  = 8'h53;
  localparam logic [7:0] ChT  = 8'h54;
  localparam logic [7:0] ChX  = 8'h58;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;

  // Gear codes
  localparam logic [1:0] GearFwd  = 2'd0;
  localparam logic [1:0] GearNeut = 2'd1;
  localparam logic [1:0] GearBack = 2'd2;

  // Framer state, one-hot
  typedef enum logic [5:0] {
    ST_HUNT = 6'b000001,
    ST_T    = 6'b000010,
    ST_X    = 6'b000100,
    ST_DATA = 6'b001000,
    ST_CR   = 6'b010000,
    ST_LF   = 6'b100000
  } frame_state_t;

  // Framer to decoder: completed frame strobe and payload bytes
  typedef struct packed {
    logic                       done;
    logic [PayloadLen-1:0][7:0] payload;
  } frame_t;

endpackage

### design/vehicle_status_frame_receiver.sv
// A result is registered: it is valid in the cycle after the LF byte of its frame is accepted.
// Throughput: one byte per cycle; a frame is 18 bytes, so one result per 18 bytes at most.
// The byte path stalls only on the LF byte while the previous result is still stalled.
// Reset (rst, synchronous, high) returns the framer to the header hunt and drops
// any pending result; the payload bytes are not cleared.
module vehicle_status_frame_receiver import vsfr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_stall,
  input  logic [7:0]         rx_byte,
  output logic               status_valid,
  input  logic               status_stall,
  output logic               auto_mode,
  output logic               estop_on,
  output logic [1:0]         gear,
  output logic [15:0]        speed,
  output logic signed [15:0] steer,
  output logic [7:0]         brake,
  output logic signed [31:0] encoder,
  output logic [7:0]         alive
);

  frame_t frame;
  logic   at_lf;

  // Hold the LF byte back only while the result register is full and stalled
  assign rx_stall = at_lf && status_valid && status_stall;

  vsfr_framer u_framer (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .rx_byte  (rx_byte),
    .at_lf    (at_lf),
    .frame    (frame)
  );

  vsfr_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .frame        (frame),
    .status_stall (status_stall),
    .status_valid (status_valid),
    .auto_mode    (auto_mode),
    .estop_on     (estop_on),
    .gear         (gear),
    .speed        (speed),
    .steer        (steer),
    .brake        (brake),
    .encoder      (encoder),
    .alive        (alive)
  );

endmodule

### design/vsfr_framer.sv
// Byte framer: header hunt, payload capture and trailer check.
module vsfr_framer import vsfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  input  logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       at_lf,
  output frame_t     frame
);

  frame_state_t               state, state_next;
  logic [IdxW-1:0]            idx, idx_next;
  logic [PayloadLen-1:0][7:0] payload;
  logic                       accept;
  logic                       done;

  assign accept = rx_valid && !rx_stall;
  assign at_lf  = (state == ST_LF);

  // Next state; a mismatched byte is dropped and the hunt restarts
  always_comb begin
    state_next = state;
    idx_next   = idx;
    done       = 1'b0;
    if (accept) begin
      unique case (state)
        ST_HUNT: state_next = (rx_byte == ChS) ? ST_T : ST_HUNT;
        ST_T:    state_next = (rx_byte == ChT) ? ST_X : ST_HUNT;
        ST_X: begin
          state_next = (rx_byte == ChX) ? ST_DATA : ST_HUNT;
          idx_next   = '0;
        end
        ST_DATA: begin
          idx_next = idx + 1'b1;
          if (idx == LastIdx) begin
            state_next = ST_CR;
          end
        end
        ST_CR:   state_next = (rx_byte == ChCr) ? ST_LF : ST_HUNT;
        ST_LF: begin
          state_next = ST_HUNT;
          done       = (rx_byte == ChLf);
        end
        default: state_next = (rx_byte == ChS) ? ST_T : ST_HUNT;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // Payload capture, no reset
  always_ff @(posedge clk) begin
    if (accept && state == ST_DATA) begin
      payload[idx] <= rx_byte;
    end
  end

  assign frame.done    = done;
  assign frame.payload = payload;

  // Payload index never runs past the last byte
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_DATA |-> idx <= LastIdx)
    else $error("payload index out of range");

  // A completed frame only comes out of the LF check
  a_done_at_lf: assert property (@(posedge clk) disable iff (rst)
    done |-> state == ST_LF && accept)
    else $error("frame done outside LF check");

endmodule

### design/vsfr_decode.sv
// Status decoder and result register.
module vsfr_decode import vsfr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  frame_t             frame,
  input  logic               status_stall,
  output logic               status_valid,
  output logic               auto_mode,
  output logic               estop_on,
  output logic [1:0]         gear,
  output logic [15:0]        speed,
  output logic signed [15:0] steer,
  output logic [7:0]         brake,
  output logic signed [31:0] encoder,
  output logic [7:0]         alive
);

  logic [1:0] gear_next;

  // Gear from byte 2
  always_comb begin
    priority if (frame.payload[2] == 8'd0) begin
      gear_next = GearFwd;
    end else if (frame.payload[2] == 8'd1) begin
      gear_next = GearNeut;
    end else begin
      gear_next = GearBack;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
    end else if (frame.done) begin
      status_valid <= 1'b1;
    end else if (!status_stall) begin
      status_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (frame.done) begin
      auto_mode <= (frame.payload[0] != 8'd0);
      estop_on  <= (frame.payload[1] != 8'd0);
      gear      <= gear_next;
      speed     <= {frame.payload[4], frame.payload[3]};
      steer     <= {frame.payload[6], frame.payload[5]};
      brake     <= frame.payload[7];
      encoder   <= {frame.payload[11], frame.payload[10],
                    frame.payload[9], frame.payload[8]};
      alive     <= frame.payload[12];
    end
  end

  // A new frame never lands on a result that is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(frame.done && status_valid && status_stall))
    else $error("result overwritten while stalled");

  // Each completed frame shows up as a result next cycle
  a_done_shows: assert property (@(posedge clk) disable iff (rst)
    frame.done |=> status_valid)
    else $error("completed frame not presented");

endmodule

### tb/testbench.sv
// Self-checking testbench for the vehicle status frame receiver.
module testbench;
  import vsfr_pkg::*;

  // Framer phases as seen by the checker's own decoder
  localparam int PhHunt  = 0;
  localparam int PhT     = 1;
  localparam int PhX     = 2;
  localparam int PhData0 = 3;
  localparam int PhCr    = PhData0 + PayloadLen;
  localparam int PhLf    = PhCr + 1;

  localparam int TotalItems = 1850;
  localparam int LongHold   = 400;
  localparam int MaxPrinted = 100;

  typedef struct packed {
    logic               auto_mode;
    logic               estop_on;
    logic [1:0]         gear;
    logic [15:0]        speed;
    logic signed [15:0] steer;
    logic [7:0]         brake;
    logic signed [31:0] encoder;
    logic [7:0]         alive;
  } status_t;

  localparam status_t NoStatus = '0;

  typedef enum {FrGood, FrBadT, FrBadX, FrBadCr, FrBadLf} frame_kind_e;

  typedef struct {
    frame_kind_e                kind;
    logic [PayloadLen-1:0][7:0] pl;
    logic [7:0]                 wrong;
    bit                         pinned;
    status_t                    want;
  } frame_row_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               rx_valid = 1'b0;
  logic               rx_stall;
  logic [7:0]         rx_byte = 8'h00;
  logic               status_valid;
  logic               status_stall = 1'b0;
  logic               auto_mode;
  logic               estop_on;
  logic [1:0]         gear;
  logic [15:0]        speed;
  logic signed [15:0] steer;
  logic [7:0]         brake;
  logic signed [31:0] encoder;
  logic [7:0]         alive;

  // Decoder state kept by the checker
  int         phase_now = PhHunt;
  logic [7:0] rx_payload [PayloadLen];

  status_t expected_status [$];
  int      errors = 0;
  int      bytes_sent = 0;
  bit      steady = 1'b0;
  bit      hold_request = 1'b0;
  bit      pin_on = 1'b0;
  status_t pin_status;

  // Directed frames; pinned rows carry a result typed in by hand
  frame_row_t directed_rows [11] = '{
    '{FrGood, '0, 8'h00, 1'b1, '{1'b0, 1'b0, GearFwd, 16'h0000, 16'sh0000, 8'h00,
                                 32'sh0000_0000, 8'h00}},
    '{FrGood, {PayloadLen{8'hFF}}, 8'h00, 1'b1,
      '{1'b1, 1'b1, GearBack, 16'hFFFF, -16'sd1, 8'hFF, -32'sd1, 8'hFF}},
    '{FrGood, 104'h00_80_00_00_00_80_80_00_80_00_03_00_01, 8'h00, 1'b1,
      '{1'b1, 1'b0, GearBack, 16'h8000, 16'sh8000, 8'h80, 32'sh8000_0000, 8'h00}},
    '{FrGood, 104'h01_7F_FF_FF_FF_00_7F_FF_00_FF_01_01_00, 8'h00, 1'b1,
      '{1'b0, 1'b1, GearNeut, 16'h00FF, 16'sh7FFF, 8'h00, 32'sh7FFF_FFFF, 8'h01}},
    '{FrGood, 104'h5A_0D_0A_58_54_53_C3_3C_12_34_02_01_01, 8'h00, 1'b0, NoStatus},
    '{FrGood, 104'hA5_78_56_34_12_81_FF_01_00_80_01_00_FF, 8'h00, 1'b0, NoStatus},
    '{FrBadT,  '0, ChS,  1'b0, NoStatus},
    '{FrBadX,  '0, ChT,  1'b0, NoStatus},
    '{FrBadCr, '0, ChS,  1'b0, NoStatus},
    '{FrBadLf, '0, ChCr, 1'b0, NoStatus},
    '{FrGood, 104'h00_11_22_33_44_55_66_77_88_99_AA_BB_CC, 8'h00, 1'b0, NoStatus}
  };

  vehicle_status_frame_receiver u_dut (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx_valid),
    .rx_stall     (rx_stall),
    .rx_byte      (rx_byte),
    .status_valid (status_valid),
    .status_stall (status_stall),
    .auto_mode    (auto_mode),
    .estop_on     (estop_on),
    .gear         (gear),
    .speed        (speed),
    .steer        (steer),
    .brake        (brake),
    .encoder      (encoder),
    .alive        (alive)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= MaxPrinted) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Advance the frame decoder by one byte; returns 1 when LF closes a frame
  function automatic bit decode_rx_byte(input logic [7:0] b, output status_t st);
    bit done;
    done = 1'b0;
    st = NoStatus;
    case (phase_now)
      PhHunt: phase_now = (b == ChS) ? PhT : PhHunt;
      PhT:    phase_now = (b == ChT) ? PhX : PhHunt;
      PhX:    phase_now = (b == ChX) ? PhData0 : PhHunt;
      PhCr:   phase_now = (b == ChCr) ? PhLf : PhHunt;
      PhLf: begin
        phase_now = PhHunt;
        if (b == ChLf) begin
          done = 1'b1;
          st.auto_mode = (rx_payload[0] != 8'h00);
          st.estop_on  = (rx_payload[1] != 8'h00);
          st.gear      = (rx_payload[2] == 8'h00) ? GearFwd :
                         (rx_payload[2] == 8'h01) ? GearNeut : GearBack;
          st.speed     = {rx_payload[4], rx_payload[3]};
          st.steer     = {rx_payload[6], rx_payload[5]};
          st.brake     = rx_payload[7];
          st.encoder   = {rx_payload[11], rx_payload[10], rx_payload[9], rx_payload[8]};
          st.alive     = rx_payload[12];
        end
      end
      default: begin
        // payload bytes are stored unchecked
        if (phase_now >= PhData0 && phase_now < PhCr) begin
          rx_payload[phase_now - PhData0] = b;
          phase_now++;
        end else begin
          phase_now = (b == ChS) ? PhT : PhHunt;
        end
      end
    endcase
    return done;
  endfunction

  // Sender idle length: mostly none, some short, a few long
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one byte, wait for it to be taken, then update the prediction
  task automatic send_byte(input logic [7:0] b);
    int      gap;
    status_t st;
    gap = idle_gap();
    if (gap > 0) begin
      rx_valid <= 1'b0;
      rx_byte  <= 8'($urandom_range(0, 255));
      repeat (gap) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (rx_stall);
    if (decode_rx_byte(b, st)) expected_status.push_back(pin_on ? pin_status : st);
    bytes_sent++;
  endtask

  // Build one frame, optionally with a corrupted header or trailer byte
  task automatic send_frame(input frame_kind_e kind, input logic [PayloadLen-1:0][7:0] pl,
                            input logic [7:0] wrong);
    logic [7:0] seq [PhLf + 1];
    seq[0] = ChS;
    seq[1] = ChT;
    seq[2] = ChX;
    for (int i = 0; i < PayloadLen; i++) seq[PhData0 + i] = pl[i];
    seq[PhCr] = ChCr;
    seq[PhLf] = ChLf;
    case (kind)
      FrBadT:  seq[1]    = wrong;
      FrBadX:  seq[2]    = wrong;
      FrBadCr: seq[PhCr] = wrong;
      FrBadLf: seq[PhLf] = wrong;
      default: ;
    endcase
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  function automatic logic [7:0] payload_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 8'h00;
    if (r < 30) return 8'hFF;
    if (r < 42) return 8'($urandom_range(0, 2));
    if (r < 47) return ChS;
    return 8'($urandom_range(0, 255));
  endfunction

  // Result receiver: random stalls, one long hold-off on request
  initial begin : receiver
    int run_left;
    int hold_left;
    bit run_hi;
    int r;
    run_left  = 0;
    hold_left = 0;
    run_hi    = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        status_stall <= 1'b1;
      end else if (steady) begin
        run_left = 0;
        status_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 55) begin
            run_hi   = 1'b0;
            run_left = $urandom_range(1, 10);
          end else if (r < 92) begin
            run_hi   = 1'b1;
            run_left = $urandom_range(1, 3);
          end else begin
            run_hi   = 1'b1;
            run_left = $urandom_range(10, 40);
          end
        end
        run_left--;
        status_stall <= run_hi;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin : status_check
    status_t want;
    if (!rst && status_valid && !status_stall) begin
      if (expected_status.size() == 0) begin
        flag_error("status item with none expected");
      end else begin
        want = expected_status.pop_front();
        if (auto_mode !== want.auto_mode)
          flag_error($sformatf("auto_mode got %0d want %0d", auto_mode, want.auto_mode));
        if (estop_on !== want.estop_on)
          flag_error($sformatf("estop_on got %0d want %0d", estop_on, want.estop_on));
        if (gear !== want.gear)
          flag_error($sformatf("gear got %0d want %0d", gear, want.gear));
        if (speed !== want.speed)
          flag_error($sformatf("speed got %0h want %0h", speed, want.speed));
        if (steer !== want.steer)
          flag_error($sformatf("steer got %0d want %0d", steer, want.steer));
        if (brake !== want.brake)
          flag_error($sformatf("brake got %0h want %0h", brake, want.brake));
        if (encoder !== want.encoder)
          flag_error($sformatf("encoder got %0d want %0d", encoder, want.encoder));
        if (alive !== want.alive)
          flag_error($sformatf("alive got %0h want %0h", alive, want.alive));
      end
    end
  end

  // Stimulus: directed frames, a drain, then random traffic
  initial begin : stimulus
    int                         frame_no;
    int                         r;
    frame_kind_e                kind;
    logic [PayloadLen-1:0][7:0] pl;
    logic [7:0]                 correct;
    logic [7:0]                 wrong;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      pin_on     = directed_rows[i].pinned;
      pin_status = directed_rows[i].want;
      send_frame(directed_rows[i].kind, directed_rows[i].pl, directed_rows[i].wrong);
      pin_on = 1'b0;
    end

    // sender holds off until every result is back
    rx_valid <= 1'b0;
    do @(posedge clk); while (expected_status.size() != 0);

    frame_no = 0;
    while (bytes_sent < TotalItems) begin
      steady = (frame_no >= 30 && frame_no < 42);
      if (frame_no == 60) hold_request = 1'b1;

      // occasional line noise between frames
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));

      for (int i = 0; i < PayloadLen; i++) pl[i] = payload_byte();
      r = $urandom_range(0, 99);
      kind = (r < 78) ? FrGood : frame_kind_e'($urandom_range(1, 4));
      correct = (kind == FrBadT) ? ChT : (kind == FrBadX) ? ChX :
                (kind == FrBadCr) ? ChCr : ChLf;
      if (correct != ChS && $urandom_range(0, 2) == 0) begin
        wrong = ChS;
      end else begin
        do wrong = 8'($urandom_range(0, 255)); while (wrong == correct);
      end
      send_frame(kind, pl, wrong);
      frame_no++;
    end
    steady = 1'b0;

    rx_valid <= 1'b0;
    do @(posedge clk); while (expected_status.size() != 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
